// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/stl_pkg.sv =====
package stl_pkg;

    localparam int CFG_W            = 11;
    localparam int MAX_TOKENS_RESET = 64;
    localparam int STATUS_W         = 3;
    localparam int KIND_W           = 4;
    localparam int START_W          = 16;
    localparam int LEN_OUT_W        = 6;
    localparam int IDX_W            = 10;
    localparam int KW_COUNT         = 6;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MANY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LONG    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNTERM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd7;
    localparam logic [KIND_W-1:0] KIND_STRING = 4'd8;
    localparam logic [KIND_W-1:0] KIND_STAR   = 4'd9;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EQUAL  = 4'd11;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd12;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd13;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd14;
    localparam logic [KIND_W-1:0] KIND_EOF    = 4'd15;
    localparam logic [KIND_W-1:0] KIND_NONE   = 4'd0;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
        '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
        '{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
        '{"I", "N", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"V", "A", "L", "U", "E", "S", 8'h00, 8'h00}
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd6, 8'd6, 8'd4, 8'd5, 8'd4, 8'd6};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_MINUS,
        MODE_STRING,
        MODE_DRAIN
    } mode_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [KIND_W-1:0]    kind;
        logic [START_W-1:0]   start;
        logic [LEN_OUT_W-1:0] len;
        logic [IDX_W-1:0]     idx;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } pair_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "*":     k = KIND_STAR;
            ",":     k = KIND_COMMA;
            "=":     k = KIND_EQUAL;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // drop keywords that cannot match once byte c sits at position idx
    function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] cand,
                                                   input logic [7:0] c,
                                                   input logic [7:0] idx);
        logic [7:0]          up;
        logic [KW_COUNT-1:0] res;
        up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        res = cand;
        for (int j = 0; j < KW_COUNT; j++) begin
            if (idx >= KW_LEN[j] || KW_TEXT[j][idx[2:0]] != up) begin
                res[j] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [KIND_W-1:0] keyword_kind(input logic [KW_COUNT-1:0] cand,
                                                       input logic [7:0] len);
        logic [KIND_W-1:0] k;
        k = KIND_IDENT;
        for (int j = KW_COUNT - 1; j >= 0; j--) begin
            if (cand[j] && KW_LEN[j] == len) begin
                k = KIND_W'(j);
            end
        end
        return k;
    endfunction

    function automatic result_t mk(input logic [STATUS_W-1:0] status,
                                   input logic [KIND_W-1:0] kind,
                                   input logic [START_W-1:0] start,
                                   input logic [LEN_OUT_W-1:0] len,
                                   input logic [IDX_W-1:0] idx);
        result_t r;
        r.status = status;
        r.kind   = kind;
        r.start  = start;
        r.len    = len;
        r.idx    = idx;
        return r;
    endfunction

endpackage

// ===== rtl/sql_token_lexer.sv =====
// Channel   Handshake              Payload
// config    cfg_write              cfg_data (token slot limit)
// input     in_valid / in_stall    text_byte, end_of_text
// output    out_valid / out_stall  status, token_kind, start_offset, value_length,
//                                  token_index, last_of_item
//
// The lexer front takes one byte every cycle while the result queue has room.
// The output stage gives one result per cycle while out_stall is low; an item
// with two results gives them in turn, and the next item waits until both are taken.
// The four-entry queue of result pairs sets how far the input runs ahead of a
// stalled output. Reset is immediate: no clearing pass, the slot limit returns to 64.
`include "assert_macros.svh"

module sql_token_lexer
    import stl_pkg::*;
#(
    parameter int VALUE_MAX   = 63,
    parameter int TOKENS_MAX  = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [KIND_W-1:0]    token_kind,
    output logic [START_W-1:0]   start_offset,
    output logic [LEN_OUT_W-1:0] value_length,
    output logic [IDX_W-1:0]     token_index,
    output logic                 last_of_item
);

    logic   q_push, q_pop;
    pair_t  q_in, q_head;
    qstat_t q_stat;

    stl_front #(
        .VALUE_MAX  (VALUE_MAX),
        .TOKENS_MAX (TOKENS_MAX),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .q_full     (q_stat.full),
        .push       (q_push),
        .push_data  (q_in)
    );

    stl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    stl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_stat.empty),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .token_kind  (token_kind),
        .start_offset(start_offset),
        .value_length(value_length),
        .token_index (token_index),
        .last_of_item(last_of_item)
    );

    `ASSERT_PROP(a_err_last, clk, rst_n, out_valid && status != ST_OK |-> last_of_item && token_kind == KIND_NONE && value_length == '0, "error result not final or not blank")
    `ASSERT_PROP(a_eof_last, clk, rst_n, out_valid && status == ST_OK && token_kind == KIND_EOF |-> last_of_item, "EOF result not final")
    `ASSERT_NEVER(a_q_over, clk, rst_n, q_stat.count > QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ASSERT_PROP(a_q_push, clk, rst_n, q_push |=> !q_stat.empty, "pushed item lost")

endmodule

// ===== rtl/stl_front.sv =====
module stl_front
    import stl_pkg::*;
#(
    parameter int VALUE_MAX   = 63,
    parameter int TOKENS_MAX  = 1024,
    parameter int OFFSET_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    input  logic             q_full,
    output logic             push,
    output pair_t            push_data
);

    localparam int LEN_W = $clog2(VALUE_MAX + 1);
    localparam int CNT_W = $clog2(TOKENS_MAX + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int TS_W  = OFFSET_BITS + 1;
    localparam logic [OFFSET_BITS-1:0] POS_TOP = '1;

    logic [CFG_W-1:0]       slots_cfg_reg;
    mode_t                  mode_reg, mode_next;
    logic [TS_W-1:0]        start_reg, start_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic                   accept;
    logic [CMP_W-1:0]       mt, limit;
    logic [KIND_W-1:0]      open_kind, pkind;
    logic                   want_eof, do_start, cont;
    result_t                res_c [2];
    logic [1:0]             n_c;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        mt = CMP_W'(slots_cfg_reg);
        if (mt == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (mt > CMP_W'(TOKENS_MAX))
        begin
            limit = CMP_W'(TOKENS_MAX);
        end
        else
        begin
            limit = mt;
        end
    end

    assign open_kind = (mode_reg == MODE_IDENT) ? keyword_kind(cand_reg, 8'(len_reg))
                                                : KIND_NUMBER;
    assign pkind     = punct_kind(text_byte);
    assign cont      = (mode_reg == MODE_IDENT) ? is_word(text_byte) : is_digit(text_byte);

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        cand_next  = cand_reg;
        pos_next   = pos_reg;
        res_c[0]   = '0;
        res_c[1]   = '0;
        n_c        = 2'd0;
        want_eof   = 1'b0;
        do_start   = 1'b0;
        if (accept)
        begin
            if (end_of_text)
            begin
                want_eof = 1'b1;
                case (mode_reg)
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        res_c[0] = mk(ST_OK, open_kind, START_W'(start_reg),
                                      LEN_OUT_W'(len_reg), IDX_W'(cnt_reg));
                        cnt_next = cnt_reg + CNT_W'(1);
                        n_c      = 2'd1;
                    end
                    MODE_MINUS:
                    begin
                        res_c[0] = mk(ST_INVALID, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                        n_c      = 2'd1;
                        want_eof = 1'b0;
                    end
                    MODE_STRING:
                    begin
                        res_c[0] = mk(ST_UNTERM, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                        n_c      = 2'd1;
                        want_eof = 1'b0;
                    end
                    MODE_DRAIN:
                    begin
                        want_eof = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                if (want_eof)
                begin
                    if (CMP_W'(cnt_next) >= limit)
                    begin
                        res_c[n_c[0]] = mk(ST_MANY, KIND_NONE, '0, '0, IDX_W'(cnt_next));
                    end
                    else
                    begin
                        res_c[n_c[0]] = mk(ST_OK, KIND_EOF, START_W'(pos_reg), '0,
                                           IDX_W'(cnt_next));
                    end
                    n_c = n_c + 2'd1;
                end
                mode_next  = MODE_IDLE;
                start_next = '0;
                len_next   = '0;
                cnt_next   = '0;
                cand_next  = '1;
                pos_next   = '0;
            end
            else
            begin
                pos_next = (pos_reg != POS_TOP) ? pos_reg + OFFSET_BITS'(1) : pos_reg;
                case (mode_reg)
                    MODE_DRAIN:
                    begin
                    end
                    MODE_STRING:
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            res_c[0]  = mk(ST_OK, KIND_STRING, START_W'(start_reg),
                                           LEN_OUT_W'(len_reg), IDX_W'(cnt_reg));
                            cnt_next  = cnt_reg + CNT_W'(1);
                            n_c       = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else if (len_reg >= LEN_W'(VALUE_MAX))
                        begin
                            res_c[0]  = mk(ST_LONG, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                            n_c       = 2'd1;
                            mode_next = MODE_DRAIN;
                        end
                        else
                        begin
                            len_next = len_reg + LEN_W'(1);
                        end
                    end
                    MODE_MINUS:
                    begin
                        if (!is_digit(text_byte))
                        begin
                            res_c[0]  = mk(ST_INVALID, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                            n_c       = 2'd1;
                            mode_next = MODE_DRAIN;
                        end
                        else if (len_reg >= LEN_W'(VALUE_MAX))
                        begin
                            res_c[0]  = mk(ST_LONG, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                            n_c       = 2'd1;
                            mode_next = MODE_DRAIN;
                        end
                        else
                        begin
                            len_next  = len_reg + LEN_W'(1);
                            mode_next = MODE_NUMBER;
                        end
                    end
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        if (cont)
                        begin
                            if (len_reg >= LEN_W'(VALUE_MAX))
                            begin
                                res_c[0]  = mk(ST_LONG, KIND_NONE, '0, '0, IDX_W'(cnt_reg));
                                n_c       = 2'd1;
                                mode_next = MODE_DRAIN;
                            end
                            else
                            begin
                                if (mode_reg == MODE_IDENT)
                                begin
                                    cand_next = narrow(cand_reg, text_byte, 8'(len_reg));
                                end
                                len_next = len_reg + LEN_W'(1);
                            end
                        end
                        else
                        begin
                            res_c[0]  = mk(ST_OK, open_kind, START_W'(start_reg),
                                           LEN_OUT_W'(len_reg), IDX_W'(cnt_reg));
                            cnt_next  = cnt_reg + CNT_W'(1);
                            n_c       = 2'd1;
                            mode_next = MODE_IDLE;
                            do_start  = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase
                // new token on this byte, after any flush above
                if (do_start && !is_space(text_byte))
                begin
                    if (CMP_W'(cnt_next) >= limit - CMP_W'(1))
                    begin
                        res_c[n_c[0]] = mk(ST_MANY, KIND_NONE, '0, '0, IDX_W'(cnt_next));
                        n_c           = n_c + 2'd1;
                        mode_next     = MODE_DRAIN;
                    end
                    else if (pkind != KIND_NONE)
                    begin
                        res_c[n_c[0]] = mk(ST_OK, pkind, START_W'(pos_reg), LEN_OUT_W'(1),
                                           IDX_W'(cnt_next));
                        n_c           = n_c + 2'd1;
                        cnt_next      = cnt_next + CNT_W'(1);
                    end
                    else
                    begin
                        start_next = TS_W'(pos_reg);
                        len_next   = LEN_W'(1);
                        cand_next  = '1;
                        if (text_byte == CH_QUOTE)
                        begin
                            start_next = TS_W'(pos_reg) + TS_W'(1);
                            len_next   = '0;
                            mode_next  = MODE_STRING;
                        end
                        else if (text_byte == CH_MINUS)
                        begin
                            mode_next = MODE_MINUS;
                        end
                        else if (is_digit(text_byte))
                        begin
                            mode_next = MODE_NUMBER;
                        end
                        else if (is_alpha(text_byte) || text_byte == CH_UNDER)
                        begin
                            cand_next = narrow('1, text_byte, 8'd0);
                            mode_next = MODE_IDENT;
                        end
                        else
                        begin
                            res_c[n_c[0]] = mk(ST_INVALID, KIND_NONE, '0, '0,
                                               IDX_W'(cnt_next));
                            n_c           = n_c + 2'd1;
                            mode_next     = MODE_DRAIN;
                        end
                    end
                end
            end
        end
    end

    assign push         = accept && (n_c != 2'd0);
    assign push_data.two = (n_c == 2'd2);
    assign push_data.r0  = res_c[0];
    assign push_data.r1  = res_c[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_cfg_reg <= CFG_W'(MAX_TOKENS_RESET);
            mode_reg      <= MODE_IDLE;
            start_reg     <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            cand_reg      <= '1;
            pos_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                slots_cfg_reg <= cfg_data;
            end
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            cand_reg  <= cand_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ===== rtl/stl_queue.sv =====
module stl_queue
    import stl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pair_t  push_data,
    input  logic   pop,
    output pair_t  head,
    output qstat_t stat
);

    pair_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/stl_back.sv =====
module stl_back
    import stl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pair_t                head,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [KIND_W-1:0]    token_kind,
    output logic [START_W-1:0]   start_offset,
    output logic [LEN_OUT_W-1:0] value_length,
    output logic [IDX_W-1:0]     token_index,
    output logic                 last_of_item
);

    pair_t   hold_reg;
    logic    busy_reg;
    logic    second_reg;
    logic    taken, finish;
    result_t cur;

    assign taken  = busy_reg && !out_stall;
    assign finish = taken && (second_reg || !hold_reg.two);
    assign pop    = !q_empty && (!busy_reg || finish);

    assign cur          = second_reg ? hold_reg.r1 : hold_reg.r0;
    assign out_valid    = busy_reg;
    assign status       = cur.status;
    assign token_kind   = cur.kind;
    assign start_offset = cur.start;
    assign value_length = cur.len;
    assign token_index  = cur.idx;
    assign last_of_item = second_reg || !hold_reg.two;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hold_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg   <= 1'b1;
            second_reg <= 1'b0;
        end
        else if (finish)
        begin
            busy_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (taken)
        begin
            second_reg <= 1'b1;
        end
    end

endmodule
